>>> sv/gn3d_pkg.sv
// Shared types, constants and arithmetic helpers for the 3D gradient noise block.
// Depends on nothing; every other file of the block imports it.
package gn3d_pkg;

    localparam int FRAC_BITS = 16;
    localparam int TBL_AW    = 8;
    localparam int LERP_W    = 20;
    localparam int FADE_W    = FRAC_BITS + 1;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    localparam logic [3:0] HASH_ZX_A = 4'd12;
    localparam logic [3:0] HASH_ZX_B = 4'd14;

    typedef logic [TBL_AW-1:0]           byte_t;
    typedef logic [FRAC_BITS-1:0]        frac_t;
    typedef logic [FADE_W-1:0]           fade_t;
    typedef logic signed [LERP_W-1:0]    lerp_t;
    typedef logic signed [FRAC_BITS+1:0] ofs_t;

    // Gradient dot product from the low four hash bits.
    function automatic lerp_t grad(byte_t hv, ofs_t x, ofs_t y, ofs_t z);
        logic [3:0]  h;
        ofs_t        u;
        ofs_t        v;
        lerp_t       su;
        lerp_t       sv;
        h = hv[3:0];
        u = (h < 4'd8) ? x : y;
        if (h < 4'd4)
            v = y;
        else if (h == HASH_ZX_A || h == HASH_ZX_B)
            v = x;
        else
            v = z;
        su = LERP_W'(u);
        sv = LERP_W'(v);
        if (h[0])
            su = -su;
        if (h[1])
            sv = -sv;
        return su + sv;
    endfunction

    // (b - a) * t, floored back to the fraction scale.
    function automatic lerp_t scale_diff(fade_t t, lerp_t a, lerp_t b);
        lerp_t                              d;
        logic signed [LERP_W+FADE_W:0]      p;
        d = b - a;
        p = d * $signed({1'b0, t});
        return p[LERP_W+FRAC_BITS-1:FRAC_BITS];
    endfunction

endpackage

>>> sv/gn3d_perm_ram.sv
// One copy of the 256-byte permutation table, one write and two read ports.
// Depends on gn3d_pkg for the index and byte types.
module gn3d_perm_ram (
    input  logic           clk,
    input  logic           en,
    input  logic           we,
    input  gn3d_pkg::byte_t waddr,
    input  gn3d_pkg::byte_t wdata,
    input  gn3d_pkg::byte_t raddr0,
    input  gn3d_pkg::byte_t raddr1,
    output gn3d_pkg::byte_t rdata0,
    output gn3d_pkg::byte_t rdata1
);
    import gn3d_pkg::*;

    byte_t mem [0:(1<<TBL_AW)-1];
    byte_t rdata0_reg;
    byte_t rdata1_reg;

    always_ff @(posedge clk)
    begin
        if (en && we)
        begin
            mem[waddr] <= wdata;
        end
        if (en)
        begin
            rdata0_reg <= mem[raddr0];
            rdata1_reg <= mem[raddr1];
        end
    end

    assign rdata0 = rdata0_reg;
    assign rdata1 = rdata1_reg;

endmodule

>>> sv/gn3d_fade.sv
// Three-stage fade curve 6t^5 - 15t^4 + 10t^3 on a fraction, result in Q1.16.
// Depends on gn3d_pkg for widths and types.
module gn3d_fade (
    input  logic            clk,
    input  logic            en,
    input  gn3d_pkg::frac_t t,
    output gn3d_pkg::fade_t fade
);
    import gn3d_pkg::*;

    localparam logic signed [21:0] FIFTEEN_Q = 22'sd15 <<< FRAC_BITS;
    localparam logic signed [21:0] TEN_Q     = 22'sd10 <<< FRAC_BITS;

    frac_t              t2_reg;
    frac_t              t_reg;
    logic signed [21:0] poly_reg;
    frac_t              t3_reg;
    logic [20:0]        poly2_reg;
    fade_t              fade_reg;

    logic [31:0]        t2_next;
    logic signed [21:0] lin;
    logic signed [38:0] q_prod;
    logic signed [21:0] poly_next;
    logic [31:0]        t3_next;
    logic [36:0]        f_prod;

    always_comb
    begin
        t2_next   = 32'(t) * 32'(t);
        lin       = $signed(22'(t) * 22'd6) - FIFTEEN_Q;
        q_prod    = lin * $signed({1'b0, t});
        poly_next = 22'(q_prod >>> FRAC_BITS) + TEN_Q;
        t3_next   = 32'(t2_reg) * 32'(t_reg);
        f_prod    = 37'(t3_reg) * 37'(poly2_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t2_reg    <= t2_next[31:16];
            t_reg     <= t;
            poly_reg  <= poly_next;
            t3_reg    <= t3_next[31:16];
            poly2_reg <= poly_reg[20:0];
            fade_reg  <= f_prod[FRAC_BITS+FADE_W-1:FRAC_BITS];
        end
    end

    assign fade = fade_reg;

endmodule

>>> sv/gradient_noise_3d_top.sv
// Top level of the 3D gradient noise block: eight-stage pipeline, table copies.
// Depends on gn3d_pkg, gn3d_perm_ram and gn3d_fade.
//
//   channel | direction | handshake          | payload
//   in      | to block  | in_valid/in_stall  | operation, table_index, table_value, coord_x/y/z
//   out     | from block| out_valid/out_stall| noise_value
//
// One word enters every cycle unless a result is stalled at the output.
// Latency is set by the chain of table lookups (three memory reads) and the lerp tree.
// Table writes give no result; each table copy is written at the stage that reads it.
// Reset clears only the valid and evaluate bits; the table holds nothing until loaded.
// A stalled output freezes the whole pipeline, so nothing is lost or repeated.
module gradient_noise_3d_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                operation,
    input  gn3d_pkg::byte_t     table_index,
    input  gn3d_pkg::byte_t     table_value,
    input  logic signed [31:0]  coord_x,
    input  logic signed [31:0]  coord_y,
    input  logic signed [31:0]  coord_z,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [17:0]  noise_value
);
    import gn3d_pkg::*;

    localparam lerp_t MAX_OUT = 20'sd131071;
    localparam lerp_t MIN_OUT = -20'sd131072;
    localparam ofs_t  ONE_Q   = 18'sd1 <<< FRAC_BITS;

    logic adv;
    logic acc0;

    // stage 1
    logic  s1_vld_reg, s1_eval_reg;
    byte_t s1_idx_reg, s1_val_reg, s1_cy_reg, s1_cz_reg;
    frac_t s1_fx_reg, s1_fy_reg, s1_fz_reg;
    // stage 2
    logic  s2_vld_reg, s2_eval_reg;
    byte_t s2_idx_reg, s2_val_reg, s2_cz_reg;
    frac_t s2_fx_reg, s2_fy_reg, s2_fz_reg;
    // stage 3
    logic  s3_vld_reg, s3_eval_reg;
    frac_t s3_fx_reg, s3_fy_reg, s3_fz_reg;
    // stage 4
    logic  s4_vld_reg, s4_eval_reg;
    lerp_t s4_g_reg [0:7];
    lerp_t s4_g_next [0:7];
    // stage 5
    logic  s5_vld_reg, s5_eval_reg;
    lerp_t s5_a_reg [0:3];
    lerp_t s5_p_reg [0:3];
    fade_t s5_v_reg, s5_w_reg;
    // stage 6
    logic  s6_vld_reg, s6_eval_reg;
    lerp_t s6_a_reg [0:1];
    lerp_t s6_p_reg [0:1];
    fade_t s6_w_reg;
    // stage 7
    logic  s7_vld_reg, s7_eval_reg;
    lerp_t s7_a_reg, s7_p_reg;
    // output
    logic  out_valid_reg;
    logic signed [17:0] noise_value_reg;

    byte_t p_x, p_x1, p_a, p_a1, p_b, p_b1;
    byte_t a_addr, b_addr, aa_addr, ab_addr, ba_addr, bb_addr;
    byte_t h_aa, h_aa1, h_ab, h_ab1, h_ba, h_ba1, h_bb, h_bb1;
    fade_t fade_u, fade_v, fade_w;
    ofs_t  x0, x1, y0, y1, z0, z1;
    lerp_t l_next [0:3];
    lerp_t m_next [0:1];
    lerp_t r_next;

    logic we0, we1, we2;

    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;
    assign acc0     = in_valid && adv;
    assign we0      = acc0 && (operation == OP_WRITE);
    assign we1      = s1_vld_reg && !s1_eval_reg;
    assign we2      = s2_vld_reg && !s2_eval_reg;

    // first lookup: p[X], p[X+1]
    gn3d_perm_ram u_ram_x (
        .clk(clk), .en(adv), .we(we0), .waddr(table_index), .wdata(table_value),
        .raddr0(coord_x[23:16]), .raddr1(coord_x[23:16] + 8'd1),
        .rdata0(p_x), .rdata1(p_x1)
    );

    assign a_addr = p_x + s1_cy_reg;
    assign b_addr = p_x1 + s1_cy_reg;

    gn3d_perm_ram u_ram_a (
        .clk(clk), .en(adv), .we(we1), .waddr(s1_idx_reg), .wdata(s1_val_reg),
        .raddr0(a_addr), .raddr1(a_addr + 8'd1), .rdata0(p_a), .rdata1(p_a1)
    );
    gn3d_perm_ram u_ram_b (
        .clk(clk), .en(adv), .we(we1), .waddr(s1_idx_reg), .wdata(s1_val_reg),
        .raddr0(b_addr), .raddr1(b_addr + 8'd1), .rdata0(p_b), .rdata1(p_b1)
    );

    assign aa_addr = p_a + s2_cz_reg;
    assign ab_addr = p_a1 + s2_cz_reg;
    assign ba_addr = p_b + s2_cz_reg;
    assign bb_addr = p_b1 + s2_cz_reg;

    gn3d_perm_ram u_ram_aa (
        .clk(clk), .en(adv), .we(we2), .waddr(s2_idx_reg), .wdata(s2_val_reg),
        .raddr0(aa_addr), .raddr1(aa_addr + 8'd1), .rdata0(h_aa), .rdata1(h_aa1)
    );
    gn3d_perm_ram u_ram_ab (
        .clk(clk), .en(adv), .we(we2), .waddr(s2_idx_reg), .wdata(s2_val_reg),
        .raddr0(ab_addr), .raddr1(ab_addr + 8'd1), .rdata0(h_ab), .rdata1(h_ab1)
    );
    gn3d_perm_ram u_ram_ba (
        .clk(clk), .en(adv), .we(we2), .waddr(s2_idx_reg), .wdata(s2_val_reg),
        .raddr0(ba_addr), .raddr1(ba_addr + 8'd1), .rdata0(h_ba), .rdata1(h_ba1)
    );
    gn3d_perm_ram u_ram_bb (
        .clk(clk), .en(adv), .we(we2), .waddr(s2_idx_reg), .wdata(s2_val_reg),
        .raddr0(bb_addr), .raddr1(bb_addr + 8'd1), .rdata0(h_bb), .rdata1(h_bb1)
    );

    // fade curves land in step with stage 4
    gn3d_fade u_fade_x (.clk(clk), .en(adv), .t(s1_fx_reg), .fade(fade_u));
    gn3d_fade u_fade_y (.clk(clk), .en(adv), .t(s1_fy_reg), .fade(fade_v));
    gn3d_fade u_fade_z (.clk(clk), .en(adv), .t(s1_fz_reg), .fade(fade_w));

    always_comb
    begin
        x0 = ofs_t'({2'b00, s3_fx_reg});
        y0 = ofs_t'({2'b00, s3_fy_reg});
        z0 = ofs_t'({2'b00, s3_fz_reg});
        x1 = x0 - ONE_Q;
        y1 = y0 - ONE_Q;
        z1 = z0 - ONE_Q;
        s4_g_next[0] = grad(h_aa,  x0, y0, z0);
        s4_g_next[1] = grad(h_ba,  x1, y0, z0);
        s4_g_next[2] = grad(h_ab,  x0, y1, z0);
        s4_g_next[3] = grad(h_bb,  x1, y1, z0);
        s4_g_next[4] = grad(h_aa1, x0, y0, z1);
        s4_g_next[5] = grad(h_ba1, x1, y0, z1);
        s4_g_next[6] = grad(h_ab1, x0, y1, z1);
        s4_g_next[7] = grad(h_bb1, x1, y1, z1);
        for (int i = 0; i < 4; i++)
        begin
            l_next[i] = s5_a_reg[i] + s5_p_reg[i];
        end
        for (int i = 0; i < 2; i++)
        begin
            m_next[i] = s6_a_reg[i] + s6_p_reg[i];
        end
        r_next = s7_a_reg + s7_p_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg    <= 1'b0;
            s1_eval_reg   <= 1'b0;
            s2_vld_reg    <= 1'b0;
            s2_eval_reg   <= 1'b0;
            s3_vld_reg    <= 1'b0;
            s3_eval_reg   <= 1'b0;
            s4_vld_reg    <= 1'b0;
            s4_eval_reg   <= 1'b0;
            s5_vld_reg    <= 1'b0;
            s5_eval_reg   <= 1'b0;
            s6_vld_reg    <= 1'b0;
            s6_eval_reg   <= 1'b0;
            s7_vld_reg    <= 1'b0;
            s7_eval_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg    <= in_valid;
            s1_eval_reg   <= operation == OP_EVAL;
            s2_vld_reg    <= s1_vld_reg;
            s2_eval_reg   <= s1_eval_reg;
            s3_vld_reg    <= s2_vld_reg;
            s3_eval_reg   <= s2_eval_reg;
            s4_vld_reg    <= s3_vld_reg;
            s4_eval_reg   <= s3_eval_reg;
            s5_vld_reg    <= s4_vld_reg;
            s5_eval_reg   <= s4_eval_reg;
            s6_vld_reg    <= s5_vld_reg;
            s6_eval_reg   <= s5_eval_reg;
            s7_vld_reg    <= s6_vld_reg;
            s7_eval_reg   <= s6_eval_reg;
            // drop write words here: they give no result
            out_valid_reg <= s7_vld_reg && s7_eval_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_idx_reg <= table_index;
            s1_val_reg <= table_value;
            s1_cy_reg  <= coord_y[23:16];
            s1_cz_reg  <= coord_z[23:16];
            s1_fx_reg  <= coord_x[15:0];
            s1_fy_reg  <= coord_y[15:0];
            s1_fz_reg  <= coord_z[15:0];

            s2_idx_reg <= s1_idx_reg;
            s2_val_reg <= s1_val_reg;
            s2_cz_reg  <= s1_cz_reg;
            s2_fx_reg  <= s1_fx_reg;
            s2_fy_reg  <= s1_fy_reg;
            s2_fz_reg  <= s1_fz_reg;

            s3_fx_reg  <= s2_fx_reg;
            s3_fy_reg  <= s2_fy_reg;
            s3_fz_reg  <= s2_fz_reg;

            for (int i = 0; i < 8; i++)
            begin
                s4_g_reg[i] <= s4_g_next[i];
            end

            for (int i = 0; i < 4; i++)
            begin
                s5_a_reg[i] <= s4_g_reg[2*i];
                s5_p_reg[i] <= scale_diff(fade_u, s4_g_reg[2*i], s4_g_reg[2*i+1]);
            end
            s5_v_reg <= fade_v;
            s5_w_reg <= fade_w;

            for (int i = 0; i < 2; i++)
            begin
                s6_a_reg[i] <= l_next[2*i];
                s6_p_reg[i] <= scale_diff(s5_v_reg, l_next[2*i], l_next[2*i+1]);
            end
            s6_w_reg <= s5_w_reg;

            s7_a_reg <= m_next[0];
            s7_p_reg <= scale_diff(s6_w_reg, m_next[0], m_next[1]);

            if (r_next > MAX_OUT)
                noise_value_reg <= MAX_OUT[17:0];
            else if (r_next < MIN_OUT)
                noise_value_reg <= MIN_OUT[17:0];
            else
                noise_value_reg <= r_next[17:0];
        end
    end

    assign out_valid   = out_valid_reg;
    assign noise_value = noise_value_reg;

    a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no word waiting at the output");

    a_write_gives_none: assert property (@(posedge clk) disable iff (!rst_n)
        (s7_vld_reg && !s7_eval_reg && !in_stall) |=> !out_valid)
        else $error("write word produced a result");

    a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(s7_vld_reg && s7_eval_reg))
        else $error("result appeared without an evaluate word behind it");

endmodule

>>> tb/sv/gradient_noise_3d_top_test.sv
// Regression bench for gradient_noise_3d_top: loads the permutation table, then
// evaluates directed and random points and checks each noise word against a local
// fixed-point predictor. Depends on gn3d_pkg and gradient_noise_3d_top.
`timescale 1ns / 1ps

module gradient_noise_3d_top_test;

    import gn3d_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               operation;
    byte_t              table_index;
    byte_t              table_value;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic               out_valid;
    logic               out_stall;
    logic signed [17:0] noise_value;

    localparam longint ONE = 64'sd65536;

    byte_t              perm_copy [256];
    logic signed [17:0] expected_noise [$];
    int                 mismatches;
    bit                 quiet;
    int                 stall_left;

    gradient_noise_3d_top DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .table_index (table_index),
        .table_value (table_value),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .coord_z     (coord_z),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .noise_value (noise_value)
    );

    always #5 clk = ~clk;

    // Arithmetic shift on a 64-bit signed value floors, as the block does.
    function automatic longint fix_mul(longint a, longint b);
        longint p;
        p = a * b;
        return p >>> 16;
    endfunction

    function automatic longint fade_curve(longint t);
        longint t3;
        longint poly;
        t3   = fix_mul(fix_mul(t, t), t);
        poly = fix_mul(t, 6 * t - 15 * ONE) + 10 * ONE;
        return fix_mul(t3, poly);
    endfunction

    function automatic longint blend(longint t, longint a, longint b);
        return a + fix_mul(t, b - a);
    endfunction

    function automatic longint corner_dot(byte_t hv, longint x, longint y, longint z);
        logic [3:0] h;
        longint     u;
        longint     v;
        h = hv[3:0];
        u = (h < 4'd8) ? x : y;
        if (h < 4'd4)
            v = y;
        else if (h == HASH_ZX_A || h == HASH_ZX_B)
            v = x;
        else
            v = z;
        if (h[0])
            u = -u;
        if (h[1])
            v = -v;
        return u + v;
    endfunction

    function automatic byte_t hash_at(longint i);
        byte_t k;
        k = i[7:0];
        return perm_copy[k];
    endfunction

    function automatic logic signed [17:0] noise_at(logic signed [31:0] px,
                                                    logic signed [31:0] py,
                                                    logic signed [31:0] pz);
        longint cx, cy, cz, fx, fy, fz, u, v, w;
        longint a, aa, ab, b, ba, bb, r;
        // cell is floor(p) mod 256, i.e. the low byte of the integer part
        cx = px[23:16];  cy = py[23:16];  cz = pz[23:16];
        fx = px[15:0];   fy = py[15:0];   fz = pz[15:0];
        u = fade_curve(fx);
        v = fade_curve(fy);
        w = fade_curve(fz);
        a  = hash_at(cx) + cy;
        aa = hash_at(a) + cz;
        ab = hash_at(a + 1) + cz;
        b  = hash_at(cx + 1) + cy;
        ba = hash_at(b) + cz;
        bb = hash_at(b + 1) + cz;
        r = blend(w,
            blend(v,
                blend(u, corner_dot(hash_at(aa), fx, fy, fz),
                         corner_dot(hash_at(ba), fx - ONE, fy, fz)),
                blend(u, corner_dot(hash_at(ab), fx, fy - ONE, fz),
                         corner_dot(hash_at(bb), fx - ONE, fy - ONE, fz))),
            blend(v,
                blend(u, corner_dot(hash_at(aa + 1), fx, fy, fz - ONE),
                         corner_dot(hash_at(ba + 1), fx - ONE, fy, fz - ONE)),
                blend(u, corner_dot(hash_at(ab + 1), fx, fy - ONE, fz - ONE),
                         corner_dot(hash_at(bb + 1), fx - ONE, fy - ONE, fz - ONE))));
        if (r > 131071)
            r = 131071;
        if (r < -131072)
            r = -131072;
        return r[17:0];
    endfunction

    // Offer one word, hold it until taken, then update the table copy or queue the noise.
    task automatic send_word(logic op, byte_t idx, byte_t val,
                             logic signed [31:0] px, logic signed [31:0] py,
                             logic signed [31:0] pz);
        int gap;
        in_valid    <= 1'b1;
        operation   <= op;
        table_index <= idx;
        table_value <= val;
        coord_x     <= px;
        coord_y     <= py;
        coord_z     <= pz;
        do
            @(posedge clk);
        while (in_stall);
        if (op == OP_WRITE)
            perm_copy[idx] = val;
        else
            expected_noise.push_back(noise_at(px, py, pz));
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 11);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_entry(byte_t idx, byte_t val);
        send_word(OP_WRITE, idx, val, $urandom, $urandom, $urandom);
    endtask

    task automatic eval_point(logic signed [31:0] px, logic signed [31:0] py,
                              logic signed [31:0] pz);
        send_word(OP_EVAL, 8'($urandom), 8'($urandom), px, py, pz);
    endtask

    function automatic logic signed [31:0] random_coord();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
            2:       return {16'($urandom_range(0, 65535)), 16'hFFFF};
            default: return {16'($urandom_range(0, 65535)), 14'h0000,
                             2'($urandom_range(0, 3))};
        endcase
    endfunction

    // Fill every entry with a shuffled permutation so no read ever hits an unset entry.
    task automatic test_table_load();
        byte_t order [256];
        byte_t tmp;
        int    j;
        for (int i = 0; i < 256; i++)
            order[i] = 8'(i);
        for (int i = 255; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 0; i < 256; i++)
            write_entry(8'(i), order[i]);
    endtask

    task automatic test_directed_points();
        eval_point(32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000);
        eval_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        eval_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
        eval_point(-32'sd1, -32'sd1, -32'sd1);
        eval_point(32'sh0000_FFFF, 32'sh0000_8000, 32'sh0000_0001);
        eval_point(32'sh00FF_8000, 32'shFF00_4000, 32'sh0100_C000);
        eval_point(32'sh8000_FFFF, 32'sh7FFF_0000, 32'shFFFF_0001);
        eval_point(32'sh0001_0000, -32'sh0001_0000, 32'sh00FF_FFFF);
        eval_point(32'sh5555_AAAA, 32'shAAAA_5555, 32'sh0F0F_F0F0);
        // write index and value extremes, then points that read them
        write_entry(8'd0, 8'd255);
        write_entry(8'd255, 8'd0);
        eval_point(32'sh0000_8000, 32'sh00FF_8000, 32'sh0000_4000);
        eval_point(32'sh00FF_C000, 32'sh0000_2000, 32'sh00FF_E000);
    endtask

    task automatic test_random_points(int count);
        for (int i = 0; i < count; i++)
            if ($urandom_range(0, 19) == 0)
                write_entry(8'($urandom), 8'($urandom));
            else
                eval_point(random_coord(), random_coord(), random_coord());
    endtask

    task automatic test_unstalled_stream(int count);
        quiet = 1'b1;
        test_random_points(count);
    endtask

    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            if (expected_noise.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected noise word %0d", noise_value);
            end
            else
            begin
                if (noise_value !== expected_noise[0])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("noise_value expected %0d actual %0d",
                                 expected_noise[0], noise_value);
                end
                void'(expected_noise.pop_front());
            end
        end
    end

    // Stall the output in bursts until the quiet part of the run.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else if (!quiet && rst_n && $urandom_range(0, 7) == 0)
        begin
            stall_left <= $urandom_range(0, 10);
            out_stall  <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("gradient_noise_3d_top regression: fail");
        $finish;
    end

    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        operation   = OP_WRITE;
        table_index = '0;
        table_value = '0;
        coord_x     = '0;
        coord_y     = '0;
        coord_z     = '0;
        out_stall   = 1'b0;
        stall_left  = 0;
        quiet       = 1'b0;
        mismatches  = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_table_load();
        test_directed_points();
        test_random_points(1500);
        test_unstalled_stream(200);
        in_valid <= 1'b0;
        while (expected_noise.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0 && expected_noise.size() == 0)
            $display("gradient_noise_3d_top regression: pass");
        else
            $display("gradient_noise_3d_top regression: fail");
        $finish;
    end

endmodule

>>> sim.f
sv/gn3d_pkg.sv
sv/gn3d_perm_ram.sv
sv/gn3d_fade.sv
sv/gradient_noise_3d_top.sv
tb/sv/gradient_noise_3d_top_test.sv
